/* sv/pteq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pteq_pkg
// Types, codes and sizes shared by the per-task event queue modules.
// ----------------------------------------------------------------------------
package pteq_pkg;

  localparam int NUM_TASKS   = 16;
  localparam int QUEUE_DEPTH = 64;

  localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int REC_DEPTH  = NUM_TASKS * QUEUE_DEPTH;
  localparam int ADDR_W     = $clog2(REC_DEPTH);
  localparam int TASK_CMP_W = 9;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_BADTASK = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [7:0]         kind;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    logic signed [31:0] pc;
    logic [7:0]         win;
  } rec_t;

  typedef struct packed {
    logic                  apply;
    logic [1:0]            op;
    logic [TASK_IDX_W-1:0] idx;
  } ptr_cmd_t;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic             empty;
    logic             drop;
  } ptr_info_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] rec_addr(input logic [TASK_IDX_W-1:0] idx,
                                                 input logic [PTR_W-1:0] ptr);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
    return a;
  endfunction

endpackage
`default_nettype wire

/* sv/pteq_rec_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pteq_rec_ram
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pteq_rec_ram import pteq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire rec_t              wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output rec_t                   rd_data
);

  rec_t mem [REC_DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* sv/pteq_ptr_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pteq_ptr_table
// Head and tail pointers of every queue, with the ring update per operation.
// ----------------------------------------------------------------------------
module pteq_ptr_table import pteq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ptr_cmd_t cmd,
  output ptr_info_t     info
);

  logic [PTR_W-1:0] head_r [NUM_TASKS];
  logic [PTR_W-1:0] tail_r [NUM_TASKS];
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_nxt;
  logic [PTR_W-1:0] h;
  logic [PTR_W-1:0] t;
  logic [PTR_W-1:0] nh;

  always_comb begin
    h        = head_r[cmd.idx];
    t        = tail_r[cmd.idx];
    nh       = ring_next(h);
    head_nxt = h;
    tail_nxt = t;
    info.head  = h;
    info.tail  = t;
    info.empty = (h == t);
    info.drop  = (cmd.op == OP_PUSH) && (nh == t);
    unique case (cmd.op)
      OP_PUSH: begin
        head_nxt = nh;
        if (nh == t) begin
          tail_nxt = ring_next(t);
        end
      end
      OP_POP: begin
        if (h != t) begin
          tail_nxt = ring_next(t);
        end
      end
      OP_FLUSH: begin
        head_nxt = '0;
        tail_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (cmd.apply) begin
      head_r[cmd.idx] <= head_nxt;
      tail_r[cmd.idx] <= tail_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/per_task_event_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// per_task_event_queue_core
// One ring buffer of event records per task: push, pop and flush.
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  operation, task id, record fields
// out      output     out_valid/out_stall status, flags, popped record
//
// push, flush, empty pop and bad task id: result registered straight from the input
// pop of a stored record: read into the record ram read register, then into the result register in ST_READ
// reset clears all pointers at once, no clearing pass; records stay unset
// a new item is taken while the previous result waits, if it is taken now
// a stalled result holds the output register and blocks the next item
// ----------------------------------------------------------------------------
module per_task_event_queue_core import pteq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [7:0]         in_task_id,
  input  wire logic [7:0]         in_event_type,
  input  wire logic signed [31:0] in_param_a,
  input  wire logic signed [31:0] in_param_b,
  input  wire logic signed [31:0] in_param_c,
  input  wire logic [7:0]         in_window_id,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic                    out_dropped_oldest,
  output logic                    out_got_event,
  output logic [7:0]              out_type,
  output logic signed [31:0]      out_param_a,
  output logic signed [31:0]      out_param_b,
  output logic signed [31:0]      out_param_c,
  output logic [7:0]              out_window_id
);

  state_t state_r, state_nxt;

  logic       accept;
  logic       task_ok;
  logic       load_now;
  logic       load_rd;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;
  logic       drop_r, drop_nxt;
  logic       got_r;
  rec_t       rec_r;

  ptr_cmd_t  cmd;
  ptr_info_t info;
  rec_t      wr_rec;
  rec_t      rd_rec;
  logic      wr_en;
  logic      rd_en;

  assign task_ok = {1'b0, in_task_id} < TASK_CMP_W'(NUM_TASKS);
  assign accept  = in_valid && !in_stall;

  assign cmd.apply = accept && task_ok;
  assign cmd.op    = in_operation;
  assign cmd.idx   = in_task_id[TASK_IDX_W-1:0];

  assign wr_rec.kind = in_event_type;
  assign wr_rec.pa   = in_param_a;
  assign wr_rec.pb   = in_param_b;
  assign wr_rec.pc   = in_param_c;
  assign wr_rec.win  = in_window_id;

  assign wr_en = cmd.apply && (in_operation == OP_PUSH);
  assign rd_en = cmd.apply && (in_operation == OP_POP) && !info.empty;

  pteq_ptr_table u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .info  (info)
  );

  pteq_rec_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rec_addr(cmd.idx, info.head)),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rec_addr(cmd.idx, info.tail)),
    .rd_data (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    load_now   = 1'b0;
    load_rd    = 1'b0;
    status_nxt = STAT_DONE;
    drop_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
        if (accept) begin
          if (rd_en) begin
            state_nxt = ST_READ;
          end else begin
            load_now = 1'b1;
            if (!task_ok) begin
              status_nxt = STAT_BADTASK;
            end else if (in_operation == OP_POP) begin
              status_nxt = STAT_EMPTY;
            end else if (in_operation == OP_PUSH) begin
              drop_nxt = info.drop;
            end
          end
        end
      end
      ST_READ: begin
        load_rd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load_now || load_rd) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_now) begin
      status_r <= status_nxt;
      drop_r   <= drop_nxt;
      got_r    <= 1'b0;
      rec_r    <= '0;
    end else if (load_rd) begin
      status_r <= STAT_DONE;
      drop_r   <= 1'b0;
      got_r    <= 1'b1;
      rec_r    <= rd_rec;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_dropped_oldest = drop_r;
  assign out_got_event      = got_r;
  assign out_type           = rec_r.kind;
  assign out_param_a        = rec_r.pa;
  assign out_param_b        = rec_r.pb;
  assign out_param_c        = rec_r.pc;
  assign out_window_id      = rec_r.win;

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("output register busy while a record read is pending");

  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_valid_r && out_got_event && state_r == ST_IDLE))
    else $error("record read did not produce a result");

  a_no_take_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> in_stall)
    else $error("input transfer taken during a record read");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_got_event && (out_dropped_oldest || out_status != STAT_DONE)))
    else $error("popped record reported together with another outcome");

endmodule
`default_nettype wire
